/* design/hbp_pkg.sv */
`timescale 1ns / 1ps

package hbp_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'b00000000;

  localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FLUSH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOCODE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADLEN = 2'd2;

  typedef enum logic [1:0] {
    K_ENCODE,
    K_FLUSH,
    K_NOCODE,
    K_BADLEN
  } kind_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SYM_W-1:0]    symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_W-1:0]    code_len;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                last;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

/* design/hbp_front.sv */
`timescale 1ns / 1ps

module hbp_front #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hbp_pkg::in_t    in_data_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output hbp_pkg::entry_t push_data_o
);

  localparam int unsigned SymW = $clog2(SYMBOL_COUNT);
  localparam int unsigned SymCmpW = hbp_pkg::SYM_W + 1;

  logic [hbp_pkg::CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [hbp_pkg::LEN_W-1:0]  len_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]    len_vld_q;

  logic [hbp_pkg::CODE_W-1:0] code_rd_q;
  logic [hbp_pkg::LEN_W-1:0]  len_rd_q;
  logic                       lv_rd_q;

  logic           a_vld_q, a_vld_d;
  hbp_pkg::kind_e a_kind_q, a_kind_d;

  logic                       accept;
  logic                       a_take;
  logic                       in_range;
  logic                       len_ok;
  logic                       tbl_wr;
  logic                       rd_en;
  logic [SymW-1:0]            idx;
  logic [hbp_pkg::CODE_W-1:0] code_mask;
  logic [hbp_pkg::CODE_W-1:0] code_masked;

  assign in_ready_o = !a_vld_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign idx        = in_data_i.symbol[SymW-1:0];
  assign in_range   = {1'b0, in_data_i.symbol} < SymCmpW'(SYMBOL_COUNT);
  assign len_ok     = in_data_i.code_len <= hbp_pkg::LEN_W'(MAX_CODE_LEN);

  always_comb begin
    if (in_data_i.code_len >= hbp_pkg::LEN_W'(hbp_pkg::CODE_W)) begin
      code_mask = '1;
    end else begin
      code_mask = (hbp_pkg::CODE_W'(1) << in_data_i.code_len) - hbp_pkg::CODE_W'(1);
    end
    code_masked = in_data_i.code_bits & code_mask;
  end

  always_comb begin
    a_take   = 1'b0;
    a_kind_d = hbp_pkg::K_ENCODE;
    case (in_data_i.opcode)
      hbp_pkg::OP_LOAD: begin
        if (!len_ok) begin
          a_take   = 1'b1;
          a_kind_d = hbp_pkg::K_BADLEN;
        end
      end
      hbp_pkg::OP_ENCODE: begin
        a_take   = 1'b1;
        a_kind_d = in_range ? hbp_pkg::K_ENCODE : hbp_pkg::K_NOCODE;
      end
      hbp_pkg::OP_FLUSH: begin
        a_take   = 1'b1;
        a_kind_d = hbp_pkg::K_FLUSH;
      end
      default: begin
        a_take = 1'b0;
      end
    endcase
  end

  assign tbl_wr = accept && (in_data_i.opcode == hbp_pkg::OP_LOAD) && len_ok && in_range;
  assign rd_en  = accept && (in_data_i.opcode == hbp_pkg::OP_ENCODE) && in_range;

  always_comb begin
    if (accept && a_take) begin
      a_vld_d = 1'b1;
    end else if (push_ready_i) begin
      a_vld_d = 1'b0;
    end else begin
      a_vld_d = a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_wr) begin
      code_mem[idx] <= code_masked;
      len_mem[idx]  <= in_data_i.code_len;
    end
    if (rd_en) begin
      code_rd_q <= code_mem[idx];
      len_rd_q  <= len_mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= '0;
      lv_rd_q   <= 1'b0;
      a_vld_q   <= 1'b0;
      a_kind_q  <= hbp_pkg::K_ENCODE;
    end else begin
      if (tbl_wr) begin
        len_vld_q[idx] <= 1'b1;
      end
      if (rd_en) begin
        lv_rd_q <= len_vld_q[idx];
      end
      if (accept && a_take) begin
        a_kind_q <= a_kind_d;
      end
      a_vld_q <= a_vld_d;
    end
  end

  assign push_valid_o = a_vld_q;

  always_comb begin
    push_data_o.code = code_rd_q;
    push_data_o.len  = len_rd_q;
    if ((a_kind_q == hbp_pkg::K_ENCODE) && (!lv_rd_q || (len_rd_q == '0))) begin
      push_data_o.kind = hbp_pkg::K_NOCODE;
    end else begin
      push_data_o.kind = a_kind_q;
    end
  end

endmodule

/* design/hbp_fifo.sv */
`timescale 1ns / 1ps

module hbp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  hbp_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output hbp_pkg::entry_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(hbp_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(hbp_pkg::QUEUE_DEPTH + 1);

  hbp_pkg::entry_t mem_q [hbp_pkg::QUEUE_DEPTH];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign push_ready_o = cnt_q != CntW'(hbp_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(hbp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(hbp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* design/hbp_back.sv */
`timescale 1ns / 1ps

module hbp_back #(
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  hbp_pkg::entry_t pop_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hbp_pkg::out_t   out_data_o
);

  localparam int unsigned AccW = MAX_CODE_LEN + hbp_pkg::BYTE_W - 1;
  localparam int unsigned CntW = $clog2(AccW + 1);

  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            out_vld_q, out_vld_d;
  hbp_pkg::out_t   out_q, out_d;

  logic                      emit_ok;
  logic                      emit_last;
  logic [CntW-1:0]           rem;
  logic [hbp_pkg::BYTE_W-1:0] emit_byte;
  logic [hbp_pkg::BYTE_W-1:0] flush_byte;
  logic [AccW-1:0]           code_ext;
  logic [CntW-1:0]           len_ext;
  logic [CntW-1:0]           base_cnt;
  logic [AccW-1:0]           enc_acc;
  logic [CntW-1:0]           enc_cnt;
  logic                      is_enc;

  assign emit_ok    = !out_vld_q || out_ready_i;
  assign rem        = cnt_q - CntW'(hbp_pkg::BYTE_W);
  assign emit_last  = rem < CntW'(hbp_pkg::BYTE_W);
  assign emit_byte  = hbp_pkg::BYTE_W'(acc_q >> rem);
  assign flush_byte = acc_q[hbp_pkg::BYTE_W-1:0] << (CntW'(hbp_pkg::BYTE_W) - cnt_q);
  assign code_ext   = AccW'(pop_data_i.code);
  assign len_ext    = CntW'(pop_data_i.len);
  assign base_cnt   = busy_q ? rem : cnt_q;
  assign enc_acc    = (acc_q << len_ext) | code_ext;
  assign enc_cnt    = base_cnt + len_ext;
  assign is_enc     = pop_data_i.kind == hbp_pkg::K_ENCODE;

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;
    pop_ready_o = 1'b0;
    if (busy_q) begin
      if (emit_ok) begin
        out_vld_d       = 1'b1;
        out_d.out_byte  = emit_byte;
        out_d.last      = emit_last;
        out_d.status    = hbp_pkg::ST_OK;
        cnt_d           = rem;
        if (emit_last) begin
          busy_d = 1'b0;
          if (pop_valid_i && is_enc) begin
            pop_ready_o = 1'b1;
            acc_d       = enc_acc;
            cnt_d       = enc_cnt;
            busy_d      = enc_cnt >= CntW'(hbp_pkg::BYTE_W);
          end
        end
      end
    end else if (pop_valid_i) begin
      case (pop_data_i.kind)
        hbp_pkg::K_ENCODE: begin
          pop_ready_o = 1'b1;
          acc_d       = enc_acc;
          cnt_d       = enc_cnt;
          busy_d      = enc_cnt >= CntW'(hbp_pkg::BYTE_W);
        end
        hbp_pkg::K_FLUSH: begin
          if (emit_ok) begin
            pop_ready_o = 1'b1;
            if (cnt_q != '0) begin
              out_vld_d      = 1'b1;
              out_d.out_byte = flush_byte;
              out_d.last     = 1'b1;
              out_d.status   = hbp_pkg::ST_OK;
              cnt_d          = '0;
            end
          end
        end
        hbp_pkg::K_NOCODE: begin
          if (emit_ok) begin
            pop_ready_o    = 1'b1;
            out_vld_d      = 1'b1;
            out_d.out_byte = hbp_pkg::ZERO_BYTE;
            out_d.last     = 1'b1;
            out_d.status   = hbp_pkg::ST_NOCODE;
          end
        end
        hbp_pkg::K_BADLEN: begin
          if (emit_ok) begin
            pop_ready_o    = 1'b1;
            out_vld_d      = 1'b1;
            out_d.out_byte = hbp_pkg::ZERO_BYTE;
            out_d.last     = 1'b1;
            out_d.status   = hbp_pkg::ST_BADLEN;
          end
        end
        default: begin
          pop_ready_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* design/huffman_bit_packer_unit.sv */
`timescale 1ns / 1ps
// An error or flush result passes the front register, the queue and the output register; the
// bytes of an encode also pass the bit buffer. Throughput: one input transfer per cycle at
// the front while the queue takes entries, one result byte per cycle at the back while
// out_ready_i is high; the output register sets this pace. Reset clears the code-length
// valid bits, the buffer's bit count, the queue and all valid flags.
module huffman_bit_packer_unit #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hbp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hbp_pkg::out_t out_data_o
);

  logic            push_valid;
  logic            push_ready;
  hbp_pkg::entry_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  hbp_pkg::entry_t pop_data;

  hbp_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  hbp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  hbp_back #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import hbp_pkg::*;

  localparam int unsigned MAX_LEN = 32;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 385;
  localparam int CALM_FROM = 150;
  localparam int CALM_TO = 250;
  localparam int HOLD_AT = 90;
  localparam int HOLD_CYCLES = 160;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;

  localparam out_t NO_RESULT = '0;
  localparam out_t NOCODE_RES = '{ZERO_BYTE, 1'b1, ST_NOCODE};
  localparam out_t BADLEN_RES = '{ZERO_BYTE, 1'b1, ST_BADLEN};

  typedef struct packed {
    in_t  item;
    logic fixed;
    logic yields;
    out_t want;
  } row_t;

  localparam int N_ROWS = 25;
  localparam row_t SCRIPT [N_ROWS] = '{
    '{'{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0},  1'b1, 1'b1, NOCODE_RES},
    '{'{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b1, 1'b0, NO_RESULT},
    '{'{OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63}, 1'b1, 1'b0, NO_RESULT},
    '{'{OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd33}, 1'b1, 1'b1, BADLEN_RES},
    '{'{OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd63}, 1'b1, 1'b1, BADLEN_RES},
    '{'{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0},  1'b1, 1'b1, NOCODE_RES},
    '{'{OP_LOAD,   8'h01, 32'h0000_00A5, 6'd8},  1'b1, 1'b0, NO_RESULT},
    '{'{OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0},  1'b1, 1'b1, '{8'hA5, 1'b1, ST_OK}},
    '{'{OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32}, 1'b1, 1'b0, NO_RESULT},
    '{'{OP_LOAD,   8'h00, 32'h0000_0000, 6'd1},  1'b1, 1'b0, NO_RESULT},
    '{'{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0},  1'b0, 1'b0, NO_RESULT},
    '{'{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0},  1'b0, 1'b0, NO_RESULT},
    '{'{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b0, 1'b0, NO_RESULT},
    '{'{OP_LOAD,   8'h02, 32'hFFFF_FFFF, 6'd3},  1'b1, 1'b0, NO_RESULT},
    '{'{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0},  1'b0, 1'b0, NO_RESULT},
    '{'{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0},  1'b0, 1'b0, NO_RESULT},
    '{'{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0},  1'b0, 1'b0, NO_RESULT},
    '{'{OP_LOAD,   8'h02, 32'h5A5A_5A5A, 6'd0},  1'b1, 1'b0, NO_RESULT},
    '{'{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0},  1'b1, 1'b1, NOCODE_RES},
    '{'{OP_LOAD,   8'h03, 32'h8000_0001, 6'd32}, 1'b1, 1'b0, NO_RESULT},
    '{'{OP_LOAD,   8'h04, 32'h0000_003F, 6'd6},  1'b1, 1'b0, NO_RESULT},
    '{'{OP_ENCODE, 8'h04, 32'h0000_0000, 6'd0},  1'b0, 1'b0, NO_RESULT},
    '{'{OP_ENCODE, 8'h03, 32'h0000_0000, 6'd0},  1'b0, 1'b0, NO_RESULT},
    '{'{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b0, 1'b0, NO_RESULT},
    '{'{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b1, 1'b0, NO_RESULT}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  logic [CODE_W-1:0] code_tab [256];
  logic [LEN_W-1:0]  len_tab [256];
  logic [6:0]        buf_bits;
  logic [2:0]        buf_count;

  out_t step_out [$];
  out_t expected_bytes [$];
  out_t head;

  bit calm;
  bit held;
  int cycle_count;
  int accepted;
  int n_loads, n_encodes, n_flushes, n_unused;
  int n_checked, n_nocode, n_badlen, n_errors;

  huffman_bit_packer_unit #(
    .SYMBOL_COUNT(256),
    .MAX_CODE_LEN(MAX_LEN)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Bit-exact prediction of one transfer; the results land in step_out.
  task automatic predict_packer(input in_t item);
    logic [63:0] acc;
    logic [63:0] keep;
    int unsigned count;
    int unsigned clen;
    out_t r;
    step_out.delete();
    case (item.opcode)
      OP_LOAD: begin
        if (item.code_len > MAX_LEN) begin
          step_out.push_back(BADLEN_RES);
        end else begin
          keep = (64'd1 << item.code_len) - 64'd1;
          code_tab[item.symbol] = item.code_bits & keep[31:0];
          len_tab[item.symbol] = item.code_len;
        end
      end
      OP_ENCODE: begin
        if (len_tab[item.symbol] == '0) begin
          step_out.push_back(NOCODE_RES);
        end else begin
          clen = len_tab[item.symbol];
          acc = ({57'd0, buf_bits} << clen) | {32'd0, code_tab[item.symbol]};
          count = buf_count + clen;
          while (count >= 8) begin
            count -= 8;
            r.out_byte = 8'(acc >> count);
            r.last = (count < 8);
            r.status = ST_OK;
            step_out.push_back(r);
          end
          keep = (64'd1 << count) - 64'd1;
          buf_bits = 7'(acc & keep);
          buf_count = 3'(count);
        end
      end
      OP_FLUSH: begin
        if (buf_count != '0) begin
          r.out_byte = {1'b0, buf_bits} << (8 - buf_count);
          r.last = 1'b1;
          r.status = ST_OK;
          step_out.push_back(r);
          buf_bits = '0;
          buf_count = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic offer(input in_t item);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    accepted++;
  endtask

  task automatic record(input in_t item, input logic fixed, input logic yields,
                        input out_t want);
    predict_packer(item);
    case (item.opcode)
      OP_LOAD:   n_loads++;
      OP_ENCODE: n_encodes++;
      OP_FLUSH:  n_flushes++;
      default:   n_unused++;
    endcase
    if (fixed) begin
      if (yields) expected_bytes.push_back(want);
    end else begin
      foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
    end
  endtask

  task automatic pause_sender();
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic logic [SYM_W-1:0] pick_live();
    int n;
    int k;
    n = 0;
    for (int i = 0; i < 256; i++) if (len_tab[i] != '0) n++;
    if (n == 0) return SYM_W'($urandom_range(0, 255));
    k = $urandom_range(0, n - 1);
    for (int i = 0; i < 256; i++) begin
      if (len_tab[i] != '0) begin
        if (k == 0) return SYM_W'(i);
        k--;
      end
    end
    return '0;
  endfunction

  function automatic in_t random_item();
    in_t item;
    int choice;
    item.opcode = OP_ENCODE;
    item.symbol = SYM_W'($urandom_range(0, 255));
    item.code_bits = $urandom;
    item.code_len = LEN_W'($urandom_range(0, 63));
    choice = $urandom_range(0, 99);
    if (choice < 22) begin
      item.opcode = OP_LOAD;
      if ($urandom_range(0, 9) == 0) item.code_len = '0;
      else if ($urandom_range(0, 1) == 0) item.code_len = LEN_W'($urandom_range(1, 8));
      else item.code_len = LEN_W'($urandom_range(1, MAX_LEN));
    end else if (choice < 26) begin
      item.opcode = OP_LOAD;
      item.code_len = LEN_W'($urandom_range(MAX_LEN + 1, 63));
    end else if (choice < 86) begin
      if ($urandom_range(0, 99) < 85) item.symbol = pick_live();
    end else if (choice < 97) begin
      item.opcode = OP_FLUSH;
    end else begin
      item.opcode = OP_UNUSED;
    end
    return item;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked++;
      if (out_data_o.status == ST_NOCODE) n_nocode++;
      if (out_data_o.status == ST_BADLEN) n_badlen++;
      if (expected_bytes.size() == 0) begin
        $display("%t unexpected result: expected none, actual %p", $time, out_data_o);
        n_errors++;
      end else begin
        head = expected_bytes.pop_front();
        if (out_data_o.out_byte !== head.out_byte) begin
          $display("%t out_byte mismatch: expected %h, actual %h",
                   $time, head.out_byte, out_data_o.out_byte);
          n_errors++;
        end
        if (out_data_o.last !== head.last) begin
          $display("%t last mismatch: expected %b, actual %b",
                   $time, head.last, out_data_o.last);
          n_errors++;
        end
        if (out_data_o.status !== head.status) begin
          $display("%t status mismatch: expected %0d, actual %0d",
                   $time, head.status, out_data_o.status);
          n_errors++;
        end
      end
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && accepted >= HOLD_AT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_t item;
    int random_done;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    random_done = 0;
    buf_bits = '0;
    buf_count = '0;
    for (int i = 0; i < 256; i++) begin
      code_tab[i] = '0;
      len_tab[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      offer(SCRIPT[r].item);
      record(SCRIPT[r].item, SCRIPT[r].fixed, SCRIPT[r].yields, SCRIPT[r].want);
      pause_sender();
    end

    while (random_done < RANDOM_ITEMS) begin
      calm = (random_done >= CALM_FROM) && (random_done < CALM_TO);
      item = random_item();
      offer(item);
      record(item, 1'b0, 1'b0, NO_RESULT);
      random_done++;
      pause_sender();
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d transfers: %0d loads, %0d encodes, %0d flushes, %0d unused opcodes.",
             accepted, n_loads, n_encodes, n_flushes, n_unused);
    $display("Checked %0d result transfers, %0d no-code and %0d bad-length among them.",
             n_checked, n_nocode, n_badlen);
    if (n_errors == 0 && expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
